// File: rtl/interval_range_map_assert.svh
// Assertion macros shared by the interval range map RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef INTERVAL_RANGE_MAP_ASSERT_SVH
`define INTERVAL_RANGE_MAP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define IRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define IRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define IRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/irm_pkg.sv
// Package for the interval range map: types, codes and default sizes.
// No dependencies.
package irm_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_MERGE,
        S_DONE
    } t_state;

    // merge walk: entries below begin, begin entry, end entry, entries past end
    typedef enum logic [1:0] {
        PH_PRE,
        PH_INB,
        PH_INE,
        PH_POST
    } t_phase;

    // per-cycle command to the cell chain
    typedef struct packed {
        logic shift;
        logic wr_en;
    } t_cell_ctl;

endpackage

// File: rtl/irm_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on nothing; widths of the result count are set by the instantiator.
interface irm_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] key_begin;
    logic signed [31:0] key_end;
    logic [7:0]         new_value;

    modport source (output valid, opcode, key_begin, key_end, new_value, input ready);
    modport sink   (input valid, opcode, key_begin, key_end, new_value, output ready);
endinterface

interface irm_out_if #(parameter int CNT_W = 7);
    logic             valid;
    logic             ready;
    logic [7:0]       read_value;
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, read_value, status, entry_count, input ready);
    modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

// File: rtl/irm_cell.sv
// One cell of the boundary table chain: holds a key and a value.
// Depends on irm_pkg; loads from its right neighbor on shift, or from the write bus.
module irm_cell import irm_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int AW       = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [AW-1:0]       i_wr_idx,
    input  logic [KEY_BITS-1:0] i_wr_key,
    input  logic [7:0]          i_wr_val,
    input  logic [KEY_BITS-1:0] i_nb_key,
    input  logic [7:0]          i_nb_val,
    output logic [KEY_BITS-1:0] o_key,
    output logic [7:0]          o_val
);

    logic [KEY_BITS-1:0] r_key;
    logic [7:0]          r_val;
    logic                wr_hit;

    assign wr_hit = i_ctl.wr_en && (i_wr_idx == AW'(CELL_IDX));

    // write after shift: the write index refers to post-shift positions
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_key <= i_wr_key;
            r_val <= i_wr_val;
        end else if (i_ctl.shift) begin
            r_key <= i_nb_key;
            r_val <= i_nb_val;
        end
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

// File: rtl/interval_range_map.sv
// Interval range map over a chain of CAPACITY+2 key/value cells; head cell is read each cycle.
// Lookup rotates the table once through the head. Assign walks the head of the chain in
// three passes: one value pass, one counting pass, one rebuild pass. An empty range skips the walk.
// One item at a time; a result waits in the output register while the next word is taken.
// Synchronous active-low reset empties the table, sets default to 0; cells are not cleared.
`include "interval_range_map_assert.svh"
module interval_range_map import irm_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    irm_in_if.sink    i_in,
    irm_out_if.source o_out
);

    localparam int NCELL = CAPACITY + 2;
    localparam int IW    = $clog2(CAPACITY + 1);
    localparam int QW    = $clog2(CAPACITY + 3);
    localparam int AW    = $clog2(CAPACITY + 2);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_commit, n_commit;
    logic   r_op;
    logic [KEY_BITS-1:0] r_kb, r_ke;
    logic [7:0]          r_nv;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_used, n_used;
    logic [QW-1:0] r_qlen, n_qlen;
    logic [QW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_last, n_last;
    logic [7:0]    r_acc, n_acc;
    logic [7:0]    r_endv, n_endv;
    logic [7:0]    r_rv, n_rv;
    logic [1:0]    r_st, n_st;
    logic [7:0]    r_default;
    logic          r_ov;
    logic [7:0]    r_o_rv;
    logic [1:0]    r_o_st;
    logic [IW-1:0] r_o_cnt;

    logic                accept;
    logic                load_out;
    logic signed [63:0]  kb_ext, ke_ext;
    logic [KEY_BITS-1:0] kb_in, ke_in;
    logic [KEY_BITS-1:0] head_key;
    logic [7:0]          head_val;
    logic                pop, emit_try, emit;
    logic [KEY_BITS-1:0] emit_key;
    logic [7:0]          emit_val;
    logic                more;
    t_cell_ctl           ctl;
    logic [AW-1:0]       wr_idx;
    logic [KEY_BITS-1:0] wr_key;
    logic [7:0]          wr_val;

    logic [KEY_BITS-1:0] cell_key [NCELL];
    logic [7:0]          cell_val [NCELL];

    // key fields reduced to KEY_BITS signed bits
    assign kb_ext = 64'(i_in.key_begin);
    assign ke_ext = 64'(i_in.key_end);
    assign kb_in  = kb_ext[KEY_BITS-1:0];
    assign ke_in  = ke_ext[KEY_BITS-1:0];

    assign accept   = i_in.valid && i_in.ready;
    assign load_out = (r_state == S_DONE) && (!r_ov || o_out.ready);
    assign i_in.ready = (r_state == S_IDLE);

    assign head_key = cell_key[0];
    assign head_val = cell_val[0];
    assign more     = (r_idx < r_used);

    // next state, walk control and chain commands
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_commit = r_commit;
        n_idx    = r_idx;
        n_used   = r_used;
        n_qlen   = r_qlen;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_acc    = r_acc;
        n_endv   = r_endv;
        n_rv     = r_rv;
        n_st     = r_st;
        pop      = 1'b0;
        emit_try = 1'b0;
        emit     = 1'b0;
        emit_key = head_key;
        emit_val = head_val;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx    = '0;
                    n_qlen   = QW'(r_used);
                    n_acc    = r_default;
                    n_commit = 1'b0;
                    n_rv     = 8'd0;
                    n_st     = ST_DONE;
                    if (i_in.opcode == OP_ASSIGN
                            && !($signed(kb_in) < $signed(ke_in))) begin
                        n_st    = ST_EMPTY;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            // rotate the table once, tracking the value at the target key
            S_FIND: begin
                if (more) begin
                    pop   = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if ((r_op == OP_LOOKUP && $signed(head_key) <= $signed(r_kb))
                            || (r_op == OP_ASSIGN && $signed(head_key) <= $signed(r_ke))) begin
                        n_acc = head_val;
                    end
                end else if (r_op == OP_LOOKUP) begin
                    n_rv    = r_acc;
                    n_state = S_DONE;
                end else begin
                    n_endv  = r_acc;
                    n_state = S_MERGE;
                    n_phase = PH_PRE;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_last  = r_default;
                end
            end
            // merge walk; counting pass first, then the committing rebuild
            S_MERGE: begin
                case (r_phase)
                    PH_PRE: begin
                        if (more && $signed(head_key) < $signed(r_kb)) begin
                            pop      = 1'b1;
                            emit_try = 1'b1;
                            n_idx    = r_idx + 1'b1;
                        end else begin
                            n_phase = PH_INB;
                        end
                    end
                    PH_INB: begin
                        emit_try = 1'b1;
                        emit_key = r_kb;
                        emit_val = r_nv;
                        n_phase  = PH_INE;
                    end
                    PH_INE: begin
                        emit_try = 1'b1;
                        emit_key = r_ke;
                        emit_val = r_endv;
                        n_phase  = PH_POST;
                    end
                    PH_POST: begin
                        if (more) begin
                            pop      = 1'b1;
                            emit_try = ($signed(head_key) > $signed(r_ke));
                            n_idx    = r_idx + 1'b1;
                        end else if (!r_commit) begin
                            if (r_cnt > QW'(CAPACITY)) begin
                                n_st    = ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_commit = 1'b1;
                                n_phase  = PH_PRE;
                                n_idx    = '0;
                                n_cnt    = '0;
                                n_last   = r_default;
                            end
                        end else begin
                            n_used  = IW'(r_cnt);
                            n_state = S_DONE;
                        end
                    end
                    default: n_phase = PH_PRE;
                endcase
                // an entry is kept only when its value differs from the one before it
                emit = emit_try && (emit_val != r_last);
                if (emit) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_last = emit_val;
                end
                if (r_commit) begin
                    n_qlen = r_qlen + QW'(emit) - QW'(pop);
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // chain command: pop shifts toward the head, writes go to the queue tail
    always_comb begin
        ctl.shift = pop;
        ctl.wr_en = r_commit ? (emit && (r_state == S_MERGE)) : pop;
        wr_idx    = pop ? AW'(r_qlen - 1'b1) : AW'(r_qlen);
        wr_key    = r_commit ? emit_key : head_key;
        wr_val    = r_commit ? emit_val : head_val;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_PRE;
            r_commit  <= 1'b0;
            r_used    <= '0;
            r_default <= 8'd0;
            r_ov      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_commit <= n_commit;
            r_used   <= n_used;
            if (i_cfg_we) begin
                r_default <= i_cfg_wdata;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_qlen <= n_qlen;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        r_acc  <= n_acc;
        r_endv <= n_endv;
        r_rv   <= n_rv;
        r_st   <= n_st;
        if (accept) begin
            r_op <= i_in.opcode;
            r_kb <= kb_in;
            r_ke <= ke_in;
            r_nv <= i_in.new_value;
        end
        if (load_out) begin
            r_o_rv  <= r_rv;
            r_o_st  <= r_st;
            r_o_cnt <= n_used;
        end
    end

    // cell chain
    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        logic [KEY_BITS-1:0] nb_key;
        logic [7:0]          nb_val;
        if (gi == NCELL - 1) begin : g_tail
            assign nb_key = wr_key;
            assign nb_val = wr_val;
        end else begin : g_mid
            assign nb_key = cell_key[gi+1];
            assign nb_val = cell_val[gi+1];
        end
        irm_cell #(
            .KEY_BITS (KEY_BITS),
            .AW       (AW),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_wr_idx (wr_idx),
            .i_wr_key (wr_key),
            .i_wr_val (wr_val),
            .i_nb_key (nb_key),
            .i_nb_val (nb_val),
            .o_key    (cell_key[gi]),
            .o_val    (cell_val[gi])
        );
    end

    assign o_out.valid       = r_ov;
    assign o_out.read_value  = r_o_rv;
    assign o_out.status      = r_o_st;
    assign o_out.entry_count = r_o_cnt;

    // checks
    `IRM_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_used <= IW'(CAPACITY), "table fill above capacity")
    `IRM_ASSERT_NOW(a_emit_bound, i_clk, i_rst_n, r_state == S_MERGE, r_cnt <= QW'(r_idx) + QW'(2), "merge emitted too many entries")
    `IRM_ASSERT_NOW(a_rebuild_len, i_clk, i_rst_n, r_state == S_MERGE && r_commit && r_phase == PH_POST && !more, r_qlen == r_cnt, "rebuilt queue length mismatch")
    `IRM_ASSERT_NEXT(a_fill_hold, i_clk, i_rst_n, !(r_state == S_MERGE && r_commit), $stable(r_used), "fill changed outside rebuild")

endmodule
